@@ design/cc20_pkg.sv @@
package cc20_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_STEPS   = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W        = $clog2(ROUND_STEPS);

  localparam logic [31:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROUND,
    S_FF,
    S_XOR
  } cc20_state_t;

  typedef struct packed {
    logic load_item;
    logic init;
    logic round_step;
    logic ff;
    logic emit;
  } cc20_cmd_t;

  typedef struct packed {
    logic need_block;
    logic step_last;
  } cc20_stat_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ design/cc20_ctrl.sv @@
module cc20_ctrl
  import cc20_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  cc20_stat_t  stat,
  output cc20_cmd_t   cmd,
  output cc20_state_t fsm_state
);

  cc20_state_t state_r, state_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic        out_free;

  assign out_free   = !out_vld_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign fsm_state  = state_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = stat.need_block ? S_INIT : S_XOR;
        end
      end
      S_INIT: begin
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (stat.step_last) begin
          state_nxt = S_FF;
        end
      end
      S_FF: begin
        state_nxt = S_XOR;
      end
      S_XOR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:  cmd.load_item  = in_tvalid;
      S_INIT:  cmd.init       = 1'b1;
      S_ROUND: cmd.round_step = 1'b1;
      S_FF:    cmd.ff         = 1'b1;
      S_XOR:   cmd.emit       = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ design/cc20_core.sv @@
module cc20_core
  import cc20_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cc20_cmd_t            cmd,
  output cc20_stat_t           stat,
  input  logic [3:0][63:0]     key,
  input  logic                 first,
  input  logic [63:0]          iv_low,
  input  logic [63:0]          iv_high,
  input  logic [31:0]          data_in,
  input  logic [2:0]           bytes_in,
  input  logic                 last_in,
  output logic [31:0]          data_out,
  output logic [2:0]           bytes_out,
  output logic                 last_out
);

  logic [31:0]       cn_r [4];
  logic [3:0]        widx_r;
  logic [STEP_W-1:0] step_r;
  logic [31:0]       x_r [16];
  logic [31:0]       x_rnd [16];
  logic [31:0]       init_w [16];
  logic [31:0]       data_r;
  logic [2:0]        bytes_r;
  logic              last_r;
  logic [31:0]       odata_r;
  logic [2:0]        obytes_r;
  logic              olast_r;
  logic              half;
  logic              diag;

  assign half = step_r[0];
  assign diag = step_r[1];

  assign stat.need_block = first || (widx_r == 4'd0);
  assign stat.step_last  = (step_r == STEP_W'(ROUND_STEPS - 1));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = SIGMA[i];
      init_w[4 + 2 * i] = key[i][31:0];
      init_w[5 + 2 * i] = key[i][63:32];
      init_w[12 + i]    = cn_r[i];
    end
  end

  // Half of a quarter round on four lanes; diagonal rounds rotate rows 1..3
  always_comb begin
    logic [1:0]  jb, jc, jd;
    logic [3:0]  ib, ic, id;
    logic [31:0] ta, tb, tc, td;
    x_rnd = x_r;
    for (int j = 0; j < 4; j++) begin
      jb = 2'(j) + {1'b0, diag};
      jc = 2'(j) + {diag, 1'b0};
      jd = 2'(j) + {diag, diag};
      ib = {2'b01, jb};
      ic = {2'b10, jc};
      id = {2'b11, jd};
      ta = x_r[j] + x_r[ib];
      td = half ? rotl32(x_r[id] ^ ta, 8) : rotl32(x_r[id] ^ ta, 16);
      tc = x_r[ic] + td;
      tb = half ? rotl32(x_r[ib] ^ tc, 7) : rotl32(x_r[ib] ^ tc, 12);
      x_rnd[j]  = ta;
      x_rnd[ib] = tb;
      x_rnd[ic] = tc;
      x_rnd[id] = td;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cn_r[i] <= '0;
      end
      widx_r <= '0;
      step_r <= '0;
    end else begin
      if (cmd.load_item && first) begin
        cn_r[0] <= iv_low[31:0];
        cn_r[1] <= iv_low[63:32];
        cn_r[2] <= iv_high[31:0];
        cn_r[3] <= iv_high[63:32];
        widx_r  <= '0;
      end
      if (cmd.init) begin
        step_r <= '0;
      end else if (cmd.round_step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.ff) begin
        cn_r[0] <= cn_r[0] + 32'd1;
      end
      if (cmd.emit) begin
        widx_r <= widx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      data_r  <= data_in;
      bytes_r <= bytes_in;
      last_r  <= last_in;
    end
    if (cmd.init) begin
      x_r <= init_w;
    end else if (cmd.round_step) begin
      x_r <= x_rnd;
    end else if (cmd.ff) begin
      for (int i = 0; i < 16; i++) begin
        x_r[i] <= x_r[i] + init_w[i];
      end
    end
    if (cmd.emit) begin
      odata_r  <= (data_r ^ x_r[widx_r]) & byte_mask(bytes_r);
      obytes_r <= bytes_r;
      olast_r  <= last_r;
    end
  end

  assign data_out  = odata_r;
  assign bytes_out = obytes_r;
  assign last_out  = olast_r;

endmodule

@@ design/chacha20_stream_cipher_unit.sv @@
// ChaCha20 cipher over a stream of 32-bit words; encrypt and decrypt are the
// same. A word with in_tuser set loads the IV and starts a message at word 0.
// A word that opens a 16-word block passes accept, state load, the round
// unit (half a quarter round on four lanes each cycle, two per round, 10
// double rounds), feed-forward add and XOR, which waits until the output
// register is free; its result is then registered in the output register.
// Any other word goes from accept straight to XOR and the output register.
// One word is in work at a time; a finished result waits in the output
// register while the next word is accepted. Write the key over the APB port
// (four 64-bit registers at byte addresses 0, 8, 16, 24) only while idle.
module chacha20_stream_cipher_unit
  import cc20_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // iv_low[63:0], iv_high[127:64], data_in[159:128], bytes_in[162:160]
  input  logic [167:0] in_tdata,
  // first[0]
  input  logic [0:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // data_out[31:0], bytes_out[34:32]
  output logic [39:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [3:0][63:0] key_r;
  cc20_cmd_t        cmd;
  cc20_stat_t       stat;
  cc20_state_t      fsm_state;
  logic [31:0]      data_out;
  logic [2:0]       bytes_out;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = key_r[cfg_paddr[4:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      key_r[cfg_paddr[4:3]] <= cfg_pwdata;
    end
  end

  cc20_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .fsm_state  (fsm_state)
  );

  cc20_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .key       (key_r),
    .first     (in_tuser[0]),
    .iv_low    (in_tdata[63:0]),
    .iv_high   (in_tdata[127:64]),
    .data_in   (in_tdata[159:128]),
    .bytes_in  (in_tdata[162:160]),
    .last_in   (in_tlast),
    .data_out  (data_out),
    .bytes_out (bytes_out),
    .last_out  (out_tlast)
  );

  assign out_tdata = {5'd0, bytes_out, data_out};

`ifndef SYNTHESIS
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while another is in work");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid)
    else $error("result not presented after emit");

  a_rounds_then_ff: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_step && stat.step_last |=> cmd.ff && fsm_state == S_FF)
    else $error("feed-forward missing after last round step");

  a_block_from_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> fsm_state == S_ROUND && cmd.round_step)
    else $error("rounds not started after state load");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int RUN_LIMIT  = 500000;
  localparam int DRAIN_WAIT = 20000;
  localparam int HOLD_LEN   = 400;

  typedef enum int {KEY_0, KEY_1, KEY_2, KEY_3} key_reg_e;

  typedef struct packed {
    logic        is_first;
    logic [63:0] iv_lo;
    logic [63:0] iv_hi;
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        is_last;
  } cipher_in_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        is_last;
  } cipher_out_t;

  class chacha_shadow;
    logic [63:0] key [4];
    logic [31:0] ctr_nonce [4];
    logic [31:0] stream_words [16];
    logic [31:0] mix [16];
    logic [3:0]  pos;
    cipher_out_t expected_cipher [$];
    int unsigned words_in;
    int unsigned words_checked;
    int unsigned bad;

    function new();
      for (int i = 0; i < 4; i++) begin
        key[i] = '0;
        ctr_nonce[i] = '0;
      end
      for (int i = 0; i < 16; i++) stream_words[i] = '0;
      pos = '0;
      words_in = 0;
      words_checked = 0;
      bad = 0;
    endfunction

    function void set_key(key_reg_e idx, logic [63:0] v);
      key[idx] = v;
    endfunction

    function logic [31:0] rot_left(logic [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
    endfunction

    function void qround(int a, int b, int c, int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rot_left(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rot_left(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rot_left(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rot_left(mix[b] ^ mix[c], 7);
    endfunction

    function void refill();
      logic [31:0] start [16];
      start[0] = 32'h6170_7865;
      start[1] = 32'h3320_646e;
      start[2] = 32'h7962_2d32;
      start[3] = 32'h6b20_6574;
      for (int k = 0; k < 4; k++) begin
        start[4 + 2 * k] = key[k][31:0];
        start[5 + 2 * k] = key[k][63:32];
        start[12 + k]    = ctr_nonce[k];
      end
      for (int i = 0; i < 16; i++) mix[i] = start[i];
      for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
        qround(0, 4, 8, 12);
        qround(1, 5, 9, 13);
        qround(2, 6, 10, 14);
        qround(3, 7, 11, 15);
        qround(0, 5, 10, 15);
        qround(1, 6, 11, 12);
        qround(2, 7, 8, 13);
        qround(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) stream_words[i] = mix[i] + start[i];
      ctr_nonce[0] = ctr_nonce[0] + 32'd1;
    endfunction

    function void note_word(cipher_in_t w);
      cipher_out_t want;
      logic [31:0] keep;
      if (w.is_first) begin
        ctr_nonce[0] = w.iv_lo[31:0];
        ctr_nonce[1] = w.iv_lo[63:32];
        ctr_nonce[2] = w.iv_hi[31:0];
        ctr_nonce[3] = w.iv_hi[63:32];
        pos = '0;
      end
      if (pos == 0) refill();
      keep = (w.nbytes >= 3'd4) ? 32'hffff_ffff : 32'hffff_ffff >> (8 * (4 - w.nbytes));
      want.data    = (w.data ^ stream_words[pos]) & keep;
      want.nbytes  = w.nbytes;
      want.is_last = w.is_last;
      pos = pos + 4'd1;
      expected_cipher.push_back(want);
      words_in++;
    endfunction

    function void flag(string msg);
      bad++;
      if (bad <= 10) $display("%0t: MISMATCH %s", $time, msg);
    endfunction

    function void check_word(cipher_out_t got);
      cipher_out_t want;
      if (expected_cipher.size() == 0) begin
        flag($sformatf("unexpected word data=%h bytes=%0d last=%0b",
                       got.data, got.nbytes, got.is_last));
        return;
      end
      want = expected_cipher.pop_front();
      words_checked++;
      if (got.data !== want.data || got.nbytes !== want.nbytes ||
          got.is_last !== want.is_last)
        flag($sformatf(
          "word %0d: expected data=%h bytes=%0d last=%0b, got data=%h bytes=%0d last=%0b",
          words_checked - 1, want.data, want.nbytes, want.is_last,
          got.data, got.nbytes, got.is_last));
    endfunction

    function int unsigned pending();
      return expected_cipher.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic [0:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  chacha_shadow shadow = new();
  int unsigned  cycle_count = 0;
  int unsigned  message_count = 0;
  int unsigned  key_settings = 1;
  bit           sender_burst = 0;
  bit           hold_off = 0;
  bit           random_started = 0;

  chacha20_stream_cipher_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic cipher_in_t word_of(logic f, logic [63:0] lo, logic [63:0] hi,
                                         logic [31:0] d, logic [2:0] n, logic l);
    cipher_in_t w;
    w.is_first = f;
    w.iv_lo    = lo;
    w.iv_hi    = hi;
    w.data     = d;
    w.nbytes   = n;
    w.is_last  = l;
    return w;
  endfunction

  task automatic push_word(cipher_in_t w);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_tdata  = {5'b0, w.nbytes, w.data, w.iv_hi, w.iv_lo};
    in_tuser  = w.is_first;
    in_tlast  = w.is_last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.note_word(w);
  endtask

  task automatic write_key(key_reg_e idx, logic [63:0] v);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = 5'(int'(idx) * 8);
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    shadow.set_key(idx, v);
  endtask

  task automatic rekey(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    write_key(KEY_0, k0);
    write_key(KEY_1, k1);
    write_key(KEY_2, k2);
    write_key(KEY_3, k3);
    key_settings++;
  endtask

  task automatic random_message();
    cipher_in_t w;
    logic [63:0] lo;
    logic [63:0] hi;
    int len;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: lo[31:0] = 32'hffff_ffff - $urandom_range(0, 2);
      2:    lo[31:0] = '0;
      default: ;
    endcase
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 20);
    sender_burst = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < len; k++) begin
      w = word_of(k == 0, k == 0 ? lo : {$urandom, $urandom},
                  k == 0 ? hi : {$urandom, $urandom}, $urandom,
                  k == len - 1 ? 3'($urandom_range(1, 4)) : 3'd4, k == len - 1);
      push_word(w);
    end
    message_count++;
  endtask

  task automatic random_stray();
    int len;
    len = $urandom_range(1, 5);
    for (int k = 0; k < len; k++)
      push_word(word_of($urandom_range(0, 3) == 0, {$urandom, $urandom},
                        {$urandom, $urandom}, $urandom, 3'($urandom_range(0, 7)),
                        1'($urandom_range(0, 1))));
  endtask

  initial begin : sink
    int gap_left;
    int mode_left;
    bit sink_burst;
    cipher_out_t got;
    out_tready = 1'b0;
    gap_left   = 0;
    mode_left  = 40;
    sink_burst = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off || gap_left > 0) begin
        out_tready = 1'b0;
        if (!hold_off) gap_left--;
      end else begin
        out_tready = 1'b1;
      end
      @(posedge clk);
      if (out_tready && out_tvalid) begin
        got.data    = out_tdata[31:0];
        got.nbytes  = out_tdata[34:32];
        got.is_last = out_tlast;
        shadow.check_word(got);
        mode_left--;
        if (mode_left == 0) begin
          sink_burst = ($urandom_range(0, 3) == 0);
          mode_left  = $urandom_range(20, 60);
        end
        gap_left = sink_burst ? 0 : $urandom_range(0, 15);
      end
    end
  end

  initial begin : sink_hold
    wait (random_started);
    while (shadow.words_in < 60) @(posedge clk);
    repeat ($urandom_range(0, 15)) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    int unsigned target;
    int waited;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // zero key, stream starts without an IV load
    push_word(word_of(1'b0, '0, '0, 32'h0000_0000, 3'd4, 1'b0));
    push_word(word_of(1'b0, '0, '0, 32'hffff_ffff, 3'd4, 1'b0));

    // all-ones key and IV: counter wraps into the second block
    rekey('1, '1, '1, '1);
    for (int k = 0; k < 17; k++)
      push_word(word_of(k == 0, '1, '1, k[0] ? 32'h0000_0000 : 32'hffff_ffff,
                        k < 8 ? 3'(k) : 3'd4, k == 16));
    push_word(word_of(1'b1, '0, '0, 32'ha5a5_a5a5, 3'd3, 1'b1));
    push_word(word_of(1'b0, '1, '0, 32'h5a5a_5a5a, 3'd4, 1'b1));
    message_count += 3;

    random_started = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 2)
        rekey({32{2'b10}}, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
      else
        rekey({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
      target = shadow.words_in + 125;
      while (shadow.words_in < target) begin
        if ($urandom_range(0, 9) == 0) random_stray();
        else random_message();
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    waited = 0;
    while (shadow.pending() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (shadow.pending() != 0)
      shadow.flag($sformatf("%0d expected words never arrived", shadow.pending()));

    $display("sent %0d words in about %0d messages under %0d key settings",
             shadow.words_in, message_count, key_settings);
    $display("checked %0d cipher words, %0d mismatches", shadow.words_checked, shadow.bad);
    if (shadow.bad == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
design/cc20_pkg.sv
design/cc20_ctrl.sv
design/cc20_core.sv
design/chacha20_stream_cipher_unit.sv
bench/testbench.sv
